[rtl/core/nrc_pkg.sv]
package nrc_pkg;

  localparam int unsigned NumChannels = 8;
  localparam int unsigned ChW = 3;
  localparam int unsigned MaxNodes = 256;
  localparam int unsigned QueueDepth = 2;

  // Flit type codes
  localparam logic [1:0] FLIT_HEAD = 2'd0;
  localparam logic [1:0] FLIT_BODY = 2'd1;
  localparam logic [1:0] FLIT_TAIL = 2'd2;

  // Routing modes
  localparam logic [2:0] MODE_RING   = 3'd0;
  localparam logic [2:0] MODE_TWO    = 3'd1;
  localparam logic [2:0] MODE_MESH   = 3'd2;
  localparam logic [2:0] MODE_HETERO = 3'd3;
  localparam logic [2:0] MODE_TORUS  = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_OWN   = 3'd1;
  localparam logic [2:0] REG_NODES = 3'd2;
  localparam logic [2:0] REG_GRID  = 3'd3;
  localparam logic [2:0] REG_SPF   = 3'd4;
  localparam logic [2:0] REG_SPL   = 3'd5;

  // Fault codes
  localparam logic [1:0] FAULT_OK      = 2'd0;
  localparam logic [1:0] FAULT_NOROUTE = 2'd1;
  localparam logic [1:0] FAULT_BADTYPE = 2'd2;

  // Ports
  localparam logic [2:0] PORT_LOCAL = 3'd0;
  localparam logic [2:0] PORT_WEST  = 3'd1;
  localparam logic [2:0] PORT_EAST  = 3'd2;
  localparam logic [2:0] PORT_NORTH = 3'd3;
  localparam logic [2:0] PORT_SOUTH = 3'd4;

  typedef struct packed {
    logic [2:0] channel;
    logic [1:0] flit_type;
    logic [7:0] dest_node;
    logic [2:0] msg_class;
  } in_item_t;

  typedef struct packed {
    logic [2:0] egress_port;
    logic [1:0] out_vc;
    logic       route_held;
    logic [1:0] fault;
    logic       all_idle;
  } out_item_t;

  typedef struct packed {
    logic [2:0] routing_mode;
    logic [7:0] own_node;
    logic [8:0] node_count;
    logic [4:0] grid_width;
    logic [3:0] spine_col_first;
    logic [3:0] spine_col_last;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    in_item_t item;
    logic     is_head;
  } job_t;

endpackage

[rtl/core/nrc_front.sv]
// Front: accepts flits, queues them for the route engine.
module nrc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid,
  output logic           in_ready,
  input  nrc_pkg::in_item_t in_data_i,
  output logic           job_valid_o,
  input  logic           job_ready_i,
  output nrc_pkg::job_t  job_o
);
  import nrc_pkg::*;

  job_t       fifo_q [QueueDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready    = (cnt_q != 2'(QueueDepth));
  assign push        = in_valid && in_ready;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = fifo_q[rd_ptr_q];

  // Payload storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q].item    <= in_data_i;
      fifo_q[wr_ptr_q].is_head <= (in_data_i.flit_type == FLIT_HEAD);
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

[rtl/core/nrc_divider.sv]
// Iterative restoring divider: 8-bit dividend by 9-bit divisor, one bit a cycle.
module nrc_divider (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] dividend_i,
  input  logic [8:0] divisor_i,
  output logic       done_o,
  output logic [7:0] quot_o,
  output logic [7:0] rem_o
);
  logic [7:0] quot_q;
  logic [7:0] rem_q;
  logic [8:0] div_q;
  logic [3:0] cnt_q;
  logic       busy_q;
  logic [8:0] trial;

  assign trial  = {rem_q, quot_q[7]};
  assign done_o = busy_q && (cnt_q == 4'd0);
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 4'd8;
    end else if (busy_q) begin
      if (cnt_q == 4'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 4'd1;
    end
  end

  // Shift-subtract step; remainder stays below the divisor (at most 256)
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= 8'd0;
      div_q  <= divisor_i;
    end else if (busy_q && cnt_q != 4'd0) begin
      if (trial >= div_q) begin
        rem_q  <= 8'(trial - div_q);
        quot_q <= {quot_q[6:0], 1'b1};
      end else begin
        rem_q  <= trial[7:0];
        quot_q <= {quot_q[6:0], 1'b0};
      end
    end
  end
endmodule

[rtl/core/nrc_back.sv]
// Back: computes routes, holds per-channel route table, drives the result register.
module nrc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nrc_pkg::cfg_t     cfg_i,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  nrc_pkg::job_t     job_i,
  output logic              out_valid,
  input  logic              out_ready,
  output nrc_pkg::out_item_t out_data_o
);
  import nrc_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DIVM  = 7'b0000010,
    ST_DIVD  = 7'b0000100,
    ST_DIVMY = 7'b0001000,
    ST_DIVDY = 7'b0010000,
    ST_ROUTE = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [NumChannels-1:0] valid_q;
  logic [2:0] port_mem_q [NumChannels];
  logic [1:0] vc_mem_q   [NumChannels];
  in_item_t   item_q;
  out_item_t  res_q;
  logic       res_valid_q;

  // column/row of own and destination node; in ring mode the remainders
  // hold both ids reduced modulo the ring size
  logic [7:0] mx_q, my_q, dx_q, dy_q;
  // rows reduced modulo the grid width (torus wrap)
  logic [7:0] myr_q, dyr_q;

  logic       div_start, div_done;
  logic [7:0] div_a, div_quot;
  logic [7:0] div_rem;
  logic [8:0] div_b;
  logic [4:0] g;
  logic [8:0] n;

  assign g = (cfg_i.grid_width == 5'd0) ? 5'd1 : cfg_i.grid_width;
  assign n = (cfg_i.node_count == 9'd0) ? 9'd1 :
             (cfg_i.node_count > 9'(MaxNodes)) ? 9'(MaxNodes) : cfg_i.node_count;

  // Dividend for each division step of a head
  assign div_a = (state_q == ST_DIVM)  ? item_q.dest_node :
                 (state_q == ST_DIVD)  ? my_q :
                 (state_q == ST_DIVMY) ? dy_q : cfg_i.own_node;
  assign div_b = (cfg_i.routing_mode == MODE_RING) ? n : {4'd0, g};

  nrc_divider u_div (
    .clk_i,
    .rst_ni,
    .start_i   (div_start),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .done_o    (div_done),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // Shorter-way rule along one dimension
  function automatic logic go_minus(input logic [8:0] me, input logic [8:0] dst,
                                    input logic [8:0] sz);
    logic [8:0] half;
    half = sz >> 1;
    if (dst > me) go_minus = (dst - me) > half;
    else          go_minus = !((me - dst) > half);
  endfunction

  // (sz - x mod sz) mod sz, with x already below sz where used
  function automatic logic [8:0] mirror(input logic [8:0] x, input logic [8:0] sz);
    logic [8:0] r;
    r = (x >= sz) ? x - sz : x;
    mirror = (r == 9'd0) ? 9'd0 : sz - r;
  endfunction

  // Route computation from registered coordinates
  logic [2:0] h_port;
  logic [1:0] h_vc;
  always_comb begin
    logic [8:0] me, d, a, b, gg;
    logic       cls0, resp, mn;
    logic [7:0] own, dst;
    own  = cfg_i.own_node;
    dst  = item_q.dest_node;
    cls0 = (item_q.msg_class == 3'd0);
    resp = (item_q.msg_class == 3'd1);
    gg   = {4'd0, g};
    h_port = PORT_LOCAL;
    h_vc   = 2'd0;
    me = 9'd0; d = 9'd0; a = 9'd0; b = 9'd0; mn = 1'b0;
    case (cfg_i.routing_mode)
      MODE_RING: begin
        me = {1'b0, own};
        d  = {1'b0, dst};
        if (own == dst) begin
          h_vc = cls0 ? 2'd0 : 2'd1;
        end else begin
          mn = go_minus(me, d, n);
          h_port = mn ? PORT_WEST : PORT_EAST;
          if (mn) begin
            a = mirror({1'b0, dx_q}, n);
            b = mirror({1'b0, mx_q}, n);
          end else begin
            a = d;
            b = me;
          end
          h_vc = (a > b) ? (cls0 ? 2'd2 : 2'd3) : (cls0 ? 2'd0 : 2'd1);
        end
      end
      MODE_TWO: begin
        if ((own == 8'd0 && dst == 8'd1) || (own == 8'd1 && dst == 8'd0))
          h_port = PORT_WEST;
        h_vc = cls0 ? 2'd0 : 2'd1;
      end
      MODE_MESH, MODE_HETERO: begin
        if (mx_q == dx_q && my_q == dy_q) begin
          h_port = PORT_LOCAL;
        end else if (cfg_i.routing_mode == MODE_HETERO) begin
          if (mx_q < {4'd0, cfg_i.spine_col_first} || mx_q > {4'd0, cfg_i.spine_col_last}
              || my_q == dy_q)
            h_port = (dx_q < mx_q) ? PORT_WEST : PORT_EAST;
          else
            h_port = (dy_q < my_q) ? PORT_NORTH : PORT_SOUTH;
        end else if (mx_q == dx_q) begin
          h_port = (dy_q < my_q) ? PORT_NORTH : PORT_SOUTH;
        end else begin
          h_port = (dx_q < mx_q) ? PORT_WEST : PORT_EAST;
        end
      end
      MODE_TORUS: begin
        if (mx_q == dx_q && my_q == dy_q) begin
          h_vc = resp ? 2'd1 : 2'd0;
        end else begin
          if (mx_q == dx_q) begin
            mn = go_minus({1'b0, my_q}, {1'b0, dy_q}, gg);
            h_port = mn ? PORT_NORTH : PORT_SOUTH;
            if (mn) begin
              a = mirror({1'b0, dyr_q}, gg);
              b = mirror({1'b0, myr_q}, gg);
            end else begin
              a = {1'b0, dy_q};
              b = {1'b0, my_q};
            end
          end else begin
            mn = go_minus({1'b0, mx_q}, {1'b0, dx_q}, gg);
            h_port = mn ? PORT_WEST : PORT_EAST;
            if (mn) begin
              a = mirror({1'b0, dx_q}, gg);
              b = mirror({1'b0, mx_q}, gg);
            end else begin
              a = {1'b0, dx_q};
              b = {1'b0, mx_q};
            end
          end
          h_vc = (a > b) ? (resp ? 2'd3 : 2'd2) : (resp ? 2'd1 : 2'd0);
        end
      end
      default: begin
        h_port = PORT_LOCAL;
        h_vc   = 2'd0;
      end
    endcase
  end

  logic need_div, is_torus;
  assign is_torus = (cfg_i.routing_mode == MODE_TORUS);
  assign need_div = (cfg_i.routing_mode == MODE_RING) || (cfg_i.routing_mode == MODE_MESH)
                 || (cfg_i.routing_mode == MODE_HETERO) || is_torus;

  assign job_ready_o = (state_q == ST_IDLE) && !res_valid_q;
  assign div_start   = ((state_q == ST_IDLE) && job_valid_i && job_ready_o &&
                        job_i.is_head && need_div) ||
                       ((state_q == ST_DIVM) && div_done) ||
                       ((state_q == ST_DIVD) && div_done && is_torus) ||
                       ((state_q == ST_DIVMY) && div_done);
  assign out_valid   = res_valid_q;
  assign out_data_o  = res_q;

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (job_valid_i && job_ready_o)
                 state_d = (job_i.is_head && need_div) ? ST_DIVM : ST_ROUTE;
      ST_DIVM: if (div_done) state_d = ST_DIVD;
      ST_DIVD: if (div_done) state_d = is_torus ? ST_DIVMY : ST_ROUTE;
      ST_DIVMY: if (div_done) state_d = ST_DIVDY;
      ST_DIVDY: if (div_done) state_d = ST_ROUTE;
      ST_ROUTE: state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Result for the current item
  out_item_t  res;
  logic [NumChannels-1:0] valid_n;
  logic       ch_ok, cur_valid;
  always_comb begin
    ch_ok     = (32'(item_q.channel) < NumChannels);
    cur_valid = ch_ok && valid_q[item_q.channel[ChW-1:0]];
    valid_n   = valid_q;
    res       = '0;
    if (!ch_ok) begin
      res.fault = FAULT_BADTYPE;
    end else begin
      case (item_q.flit_type)
        FLIT_HEAD: begin
          res.egress_port = h_port;
          res.out_vc      = h_vc;
          res.route_held  = 1'b1;
          valid_n[item_q.channel[ChW-1:0]] = 1'b1;
        end
        FLIT_BODY, FLIT_TAIL: begin
          if (cur_valid) begin
            res.egress_port = port_mem_q[item_q.channel[ChW-1:0]];
            res.out_vc      = vc_mem_q[item_q.channel[ChW-1:0]];
          end else begin
            res.fault = FAULT_NOROUTE;
          end
          if (item_q.flit_type == FLIT_TAIL) valid_n[item_q.channel[ChW-1:0]] = 1'b0;
          res.route_held = valid_n[item_q.channel[ChW-1:0]];
        end
        default: begin
          res.fault      = FAULT_BADTYPE;
          res.route_held = cur_valid;
        end
      endcase
    end
    res.all_idle = (valid_n == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_ROUTE) begin
        valid_q     <= valid_n;
        res_valid_q <= 1'b1;
      end else if (out_valid && out_ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && job_valid_i && job_ready_o) item_q <= job_i.item;
    if (state_q == ST_DIVM && div_done) begin
      mx_q <= div_rem;
      my_q <= div_quot;
    end
    if (state_q == ST_DIVD && div_done) begin
      dx_q <= div_rem;
      dy_q <= div_quot;
    end
    if (state_q == ST_DIVMY && div_done) myr_q <= div_rem;
    if (state_q == ST_DIVDY && div_done) dyr_q <= div_rem;
    if (state_q == ST_ROUTE) begin
      res_q <= res;
      if (ch_ok && item_q.flit_type == FLIT_HEAD) begin
        port_mem_q[item_q.channel[ChW-1:0]] <= h_port;
        vc_mem_q[item_q.channel[ChW-1:0]]   <= h_vc;
      end
    end
  end
endmodule

[rtl/core/noc_route_compute.sv]
// Route computation for a network-on-chip router.
// Input channel (in_valid/in_ready, in_data_i): one flit per item carrying
// channel, flit type, destination and message class.
// Output channel (out_valid/out_ready, out_data_o): one result per flit with
// port, virtual channel, route-held flag, fault code and all-idle flag.
// Config channel (cfg_valid/cfg_ready, cfg_index_i, cfg_data_i): writes the
// routing registers; write only while no flit is in flight.
// Body, tail, bad and two-node head flits go from IDLE through ROUTE;
// ring, mesh and heterogeneous heads first pass DIVM and DIVD, and
// torus heads also DIVMY and DIVDY. A shared bit-serial divider splits
// own and destination ids into column and row, or reduces them modulo the
// ring size; torus adds two divisions to reduce rows modulo the grid width.
// One item is in the engine at a time: the next is taken only once the
// result has left and the engine is back in IDLE.
// A two-entry queue decouples intake from the route engine, so flits keep
// being accepted while a result waits, until the queue is full.
// Reset clears all route valid bits and restores register defaults.
// A stalled receiver holds the result register and the engine stops.
module noc_route_compute (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid,
  output logic                in_ready,
  input  nrc_pkg::in_item_t   in_data_i,
  output logic                out_valid,
  input  logic                out_ready,
  output nrc_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index_i,
  input  logic [8:0]          cfg_data_i
);
  import nrc_pkg::*;

  cfg_t  cfg_q;
  job_t  job;
  logic  job_valid, job_ready;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.routing_mode    <= MODE_RING;
      cfg_q.own_node        <= 8'd0;
      cfg_q.node_count      <= 9'd16;
      cfg_q.grid_width      <= 5'd4;
      cfg_q.spine_col_first <= 4'd3;
      cfg_q.spine_col_last  <= 4'd4;
    end else if (cfg_valid) begin
      case (cfg_index_i)
        REG_MODE:  cfg_q.routing_mode    <= cfg_data_i[2:0];
        REG_OWN:   cfg_q.own_node        <= cfg_data_i[7:0];
        REG_NODES: cfg_q.node_count      <= cfg_data_i;
        REG_GRID:  cfg_q.grid_width      <= cfg_data_i[4:0];
        REG_SPF:   cfg_q.spine_col_first <= cfg_data_i[3:0];
        REG_SPL:   cfg_q.spine_col_last  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  nrc_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid,
    .in_ready,
    .in_data_i,
    .job_valid_o(job_valid),
    .job_ready_i(job_ready),
    .job_o      (job)
  );

  nrc_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg_q),
    .job_valid_i(job_valid),
    .job_ready_o(job_ready),
    .job_i      (job),
    .out_valid,
    .out_ready,
    .out_data_o
  );
endmodule

[rtl/core/nrc_checker.sv]
// Port-level checks for the route computation block.
module nrc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid,
  input logic               out_ready,
  input nrc_pkg::out_item_t out_data_o
);
  import nrc_pkg::*;

  // Result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data_o))
    else $error("result changed under stall");

  // A held route means the block is not idle
  a_held_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data_o.route_held |-> !out_data_o.all_idle)
    else $error("route held while all idle");

  // Faulted results carry no route
  a_fault_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data_o.fault != FAULT_OK |-> out_data_o.egress_port == PORT_LOCAL
      && out_data_o.out_vc == 2'd0)
    else $error("faulted item carries a route");

  // Fault codes stay in range
  a_fault_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data_o.fault != 2'd3)
    else $error("undefined fault code");

  // Nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid)
    else $error("result after reset");
endmodule

bind noc_route_compute nrc_checker u_nrc_checker (
  .clk_i,
  .rst_ni,
  .out_valid,
  .out_ready,
  .out_data_o
);

[verif/tb_noc_route_compute.sv]
module tb_noc_route_compute;
  timeunit 1ns;
  timeprecision 1ps;
  import nrc_pkg::*;

  localparam logic [1:0] FLIT_BAD = 2'd3;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_WAIT = 40;
  localparam int unsigned HOLD_CYCLES = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data_i = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index_i = '0;
  logic [8:0] cfg_data_i = '0;

  noc_route_compute dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid(in_valid), .in_ready(in_ready), .in_data_i(in_data_i),
    .out_valid(out_valid), .out_ready(out_ready), .out_data_o(out_data_o),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // shadow registers and per-channel route table
  logic [2:0] mode_r = MODE_RING;
  logic [7:0] own_r = 8'd0;
  logic [8:0] nodes_r = 9'd16;
  logic [4:0] grid_r = 5'd4;
  logic [3:0] spf_r = 4'd3;
  logic [3:0] spl_r = 4'd4;
  logic [NumChannels-1:0] route_vld = '0;
  logic [2:0] route_port [NumChannels];
  logic [1:0] route_vc [NumChannels];

  out_item_t route_q[$];
  int unsigned mismatches = 0;
  int unsigned cyc = 0;
  int unsigned hold_until = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cyc = 0;

  function automatic int unsigned mirror_pos(int unsigned x, int unsigned n);
    return (n - (x % n)) % n;
  endfunction

  function automatic bit take_minus(int unsigned me, int unsigned dst, int unsigned n);
    if (dst > me) return (dst - me) > n / 2;
    return !((me - dst) > n / 2);
  endfunction

  function automatic void ring_route(int unsigned dst, int unsigned cls,
                                     output int unsigned p, output int unsigned v);
    int unsigned n, me, d;
    n = nodes_r;
    if (n == 0) n = 1;
    if (n > MaxNodes) n = MaxNodes;
    me = own_r;
    d = dst;
    if (me == d) begin
      p = PORT_LOCAL;
      v = (cls == 0) ? 0 : 1;
      return;
    end
    p = take_minus(me, d, n) ? PORT_WEST : PORT_EAST;
    if (p == PORT_WEST) begin
      d = mirror_pos(d, n);
      me = mirror_pos(me, n);
    end
    if (d > me) v = (cls == 0) ? 2 : 3;
    else v = (cls == 0) ? 0 : 1;
  endfunction

  function automatic void torus_route(int unsigned dst, int unsigned cls,
                                      output int unsigned p, output int unsigned v);
    int unsigned g, mx, my, dx, dy, a, b;
    bit resp;
    g = (grid_r == 0) ? 1 : grid_r;
    mx = own_r % g; my = own_r / g;
    dx = dst % g; dy = dst / g;
    resp = (cls == 1);
    if (mx == dx && my == dy) begin
      p = PORT_LOCAL;
      v = resp ? 1 : 0;
      return;
    end
    if (mx == dx) begin
      p = take_minus(my, dy, g) ? PORT_NORTH : PORT_SOUTH;
      a = dy; b = my;
      if (p == PORT_NORTH) begin a = mirror_pos(a, g); b = mirror_pos(b, g); end
    end else begin
      p = take_minus(mx, dx, g) ? PORT_WEST : PORT_EAST;
      a = dx; b = mx;
      if (p == PORT_WEST) begin a = mirror_pos(a, g); b = mirror_pos(b, g); end
    end
    if (a > b) v = resp ? 3 : 2;
    else v = resp ? 1 : 0;
  endfunction

  function automatic int unsigned mesh_route(int unsigned dst, bit hetero);
    int unsigned g, mx, my, dx, dy;
    g = (grid_r == 0) ? 1 : grid_r;
    mx = own_r % g; my = own_r / g;
    dx = dst % g; dy = dst / g;
    if (mx == dx && my == dy) return PORT_LOCAL;
    if (hetero) begin
      if (mx < spf_r || mx > spl_r || my == dy) return (dx < mx) ? PORT_WEST : PORT_EAST;
      return (dy < my) ? PORT_NORTH : PORT_SOUTH;
    end
    if (mx == dx) return (dy < my) ? PORT_NORTH : PORT_SOUTH;
    return (dx < mx) ? PORT_WEST : PORT_EAST;
  endfunction

  // expected result of one flit; updates the route table
  function automatic out_item_t predict_route(in_item_t it);
    out_item_t r;
    int unsigned p, v;
    r = '0;
    p = 0;
    v = 0;
    case (it.flit_type)
      FLIT_HEAD: begin
        case (mode_r)
          MODE_RING:   ring_route(it.dest_node, it.msg_class, p, v);
          MODE_TWO: begin
            p = PORT_LOCAL;
            if ((own_r == 0 && it.dest_node == 1) || (own_r == 1 && it.dest_node == 0))
              p = PORT_WEST;
            v = (it.msg_class == 0) ? 0 : 1;
          end
          MODE_MESH:   p = mesh_route(it.dest_node, 1'b0);
          MODE_HETERO: p = mesh_route(it.dest_node, 1'b1);
          MODE_TORUS:  torus_route(it.dest_node, it.msg_class, p, v);
          default: begin p = PORT_LOCAL; v = 0; end
        endcase
        route_port[it.channel] = p[2:0];
        route_vc[it.channel] = v[1:0];
        route_vld[it.channel] = 1'b1;
        r.egress_port = p[2:0];
        r.out_vc = v[1:0];
        r.fault = FAULT_OK;
      end
      FLIT_BODY, FLIT_TAIL: begin
        if (route_vld[it.channel]) begin
          r.egress_port = route_port[it.channel];
          r.out_vc = route_vc[it.channel];
          r.fault = FAULT_OK;
        end else begin
          r.fault = FAULT_NOROUTE;
        end
        if (it.flit_type == FLIT_TAIL) route_vld[it.channel] = 1'b0;
      end
      default: r.fault = FAULT_BADTYPE;
    endcase
    r.route_held = route_vld[it.channel];
    r.all_idle = (route_vld == '0);
    return r;
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc < hold_until) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && out_valid && out_ready) begin
      if (route_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        exp_r = route_q.pop_front();
        if (out_data_o.egress_port !== exp_r.egress_port ||
            out_data_o.out_vc !== exp_r.out_vc ||
            out_data_o.route_held !== exp_r.route_held ||
            out_data_o.fault !== exp_r.fault || out_data_o.all_idle !== exp_r.all_idle) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected %p actual %p", $realtime, exp_r, out_data_o);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cyc <= 0;
    else quiet_cyc <= quiet_cyc + 1;
    if (quiet_cyc >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_flit(logic [2:0] ch, logic [1:0] ty, logic [7:0] dst, logic [2:0] cls);
    in_item_t it;
    out_item_t exp_r;
    it = '{channel: ch, flit_type: ty, dest_node: dst, msg_class: cls};
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready);
    exp_r = predict_route(it);
    route_q = {route_q, exp_r};
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (route_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      REG_MODE:  mode_r = val[2:0];
      REG_OWN:   own_r = val[7:0];
      REG_NODES: nodes_r = val;
      REG_GRID:  grid_r = val[4:0];
      REG_SPF:   spf_r = val[3:0];
      REG_SPL:   spl_r = val[3:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [2:0] md, logic [7:0] own, logic [8:0] nodes,
                           logic [4:0] grid, logic [3:0] spf, logic [3:0] spl);
    drain_results();
    write_reg(REG_MODE, {6'd0, md});
    write_reg(REG_OWN, {1'b0, own});
    write_reg(REG_NODES, nodes);
    write_reg(REG_GRID, {4'd0, grid});
    write_reg(REG_SPF, {5'd0, spf});
    write_reg(REG_SPL, {5'd0, spl});
    cfg_valid <= 1'b0;
  endtask

  // random settings, mostly assigned modes and small grids
  task automatic random_config();
    logic [2:0] md;
    logic [8:0] nodes;
    logic [4:0] grid;
    md = ($urandom_range(9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
    case ($urandom_range(5))
      0: nodes = 9'd0;
      1: nodes = 9'd256;
      2: nodes = 9'($urandom_range(257, 511));
      default: nodes = 9'($urandom_range(1, 32));
    endcase
    case ($urandom_range(5))
      0: grid = 5'd0;
      1: grid = 5'd16;
      2: grid = 5'($urandom_range(17, 31));
      default: grid = 5'($urandom_range(1, 8));
    endcase
    write_all(md, 8'($urandom), nodes, grid, 4'($urandom), 4'($urandom));
  endtask

  // whole packets with random content, some noise flits
  task automatic random_packets(int unsigned n_items);
    int unsigned sent;
    logic [2:0] ch;
    logic [7:0] dst;
    logic [2:0] cls;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 15) begin
        send_flit(3'($urandom), 2'($urandom), 8'($urandom), 3'($urandom));
        sent++;
      end else begin
        ch = 3'($urandom);
        dst = ($urandom_range(3) == 0) ? own_r : 8'($urandom);
        cls = 3'($urandom);
        send_flit(ch, FLIT_HEAD, dst, cls);
        repeat ($urandom_range(2)) begin
          send_flit(ch, FLIT_BODY, 8'($urandom), 3'($urandom));
          sent++;
        end
        send_flit(ch, FLIT_TAIL, 8'($urandom), 3'($urandom));
        sent += 2;
      end
    end
  endtask

  task automatic test_directed();
    // ring defaults: local, plus, minus, half distance, beyond size
    send_flit(3'd0, FLIT_HEAD, 8'd0, 3'd0);
    send_flit(3'd1, FLIT_HEAD, 8'd3, 3'd1);
    send_flit(3'd2, FLIT_HEAD, 8'd12, 3'd0);
    send_flit(3'd3, FLIT_HEAD, 8'd8, 3'd1);
    send_flit(3'd4, FLIT_HEAD, 8'd255, 3'd7);
    send_flit(3'd1, FLIT_BODY, 8'd0, 3'd0);
    send_flit(3'd1, FLIT_TAIL, 8'd0, 3'd0);
    send_flit(3'd1, FLIT_BODY, 8'd0, 3'd0);
    send_flit(3'd5, FLIT_TAIL, 8'd0, 3'd0);
    send_flit(3'd2, FLIT_BAD, 8'd0, 3'd0);
    send_flit(3'd7, FLIT_BAD, 8'd0, 3'd0);
    // two-node
    write_all(MODE_TWO, 8'd1, 9'd16, 5'd4, 4'd3, 4'd4);
    send_flit(3'd6, FLIT_HEAD, 8'd0, 3'd0);
    send_flit(3'd6, FLIT_TAIL, 8'd5, 3'd2);
    // mesh
    write_all(MODE_MESH, 8'd5, 9'd16, 5'd4, 4'd3, 4'd4);
    send_flit(3'd0, FLIT_HEAD, 8'd6, 3'd0);
    send_flit(3'd1, FLIT_HEAD, 8'd1, 3'd0);
    send_flit(3'd2, FLIT_HEAD, 8'd13, 3'd1);
    // heterogeneous, own node on a spine column
    write_all(MODE_HETERO, 8'd7, 9'd16, 5'd4, 4'd3, 4'd4);
    send_flit(3'd3, FLIT_HEAD, 8'd15, 3'd0);
    send_flit(3'd4, FLIT_HEAD, 8'd4, 3'd0);
    // torus with wrap, then zero sizes
    write_all(MODE_TORUS, 8'd0, 9'd0, 5'd4, 4'd0, 4'd15);
    send_flit(3'd5, FLIT_HEAD, 8'd3, 3'd1);
    send_flit(3'd6, FLIT_HEAD, 8'd12, 3'd0);
    write_all(MODE_RING, 8'd255, 9'd0, 5'd0, 4'd15, 4'd0);
    send_flit(3'd7, FLIT_HEAD, 8'd0, 3'd0);
    drain_results();
  endtask

  task automatic run_phase(int unsigned in_idle, int unsigned out_stall);
    idle_pct = in_idle;
    stall_pct = out_stall;
    repeat (3) begin
      random_config();
      random_packets(48);
    end
  endtask

  task automatic test_backpressure();
    drain_results();
    idle_pct = 0;
    stall_pct = 0;
    hold_until = cyc + HOLD_CYCLES;
    random_packets(16);
    drain_results();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    run_phase(0, 0);
    run_phase(81, 0);
    run_phase(0, 81);
    run_phase(22, 22);
    test_backpressure();
    drain_results();
    if (mismatches == 0 && route_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
